[src/sef_pkg.sv]
// ----------------------------------------------------------------------------
// sef_pkg - shared types and constants of the 3x3 Sobel edge filter
// Pixel and register widths, register indexes, reset values, the pipeline
// control word and the status word of the gradient pipeline.
// ----------------------------------------------------------------------------
package sef_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;
    localparam int ROW_W      = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 8'd1;

    // register reset values
    localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 12'd720;
    localparam logic [CFG_DATA_W-1:0] FRAME_COLS_RST = 12'd1280;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    // per-word control that travels along the pipeline
    typedef struct packed {
        logic produce;   // interior pixel, gives a result
        logic last;      // final result of the frame
    } t_ctl;

    // occupancy of the gradient pipeline, used for input credit
    typedef struct packed {
        logic win_valid;
        logic grad_valid;
    } t_pipe_status;

endpackage

[src/sef_if.sv]
// ----------------------------------------------------------------------------
// sef_if - valid/ready channels of the Sobel edge filter
// Pixel input channel, edge output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface sef_pix_if;
    logic                       valid;
    logic                       ready;
    logic [sef_pkg::PIX_W-1:0]  pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface sef_out_if;
    logic                       valid;
    logic                       ready;
    logic [sef_pkg::PIX_W-1:0]  edge_pixel;
    logic                       frame_last;

    modport source (output valid, output edge_pixel, output frame_last, input ready);
    modport sink   (input valid, input edge_pixel, input frame_last, output ready);
endinterface

interface sef_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sef_pkg::CFG_IDX_W-1:0]   index;
    logic [sef_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sef_line_mem.sv]
// ----------------------------------------------------------------------------
// sef_line_mem - two-row line buffer
// One synchronous memory, one word per column holding the two previous rows.
// Registered read, one write per cycle, write data forwarded on a same-entry
// read in the same cycle.
// ----------------------------------------------------------------------------
module sef_line_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [2*sef_pkg::PIX_W-1:0]   o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [2*sef_pkg::PIX_W-1:0]   i_wr_data
);

    logic [2*sef_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [2*sef_pkg::PIX_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, bypass when the entry is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/sef_grad.sv]
// ----------------------------------------------------------------------------
// sef_grad - 3x3 window and Sobel gradient pipeline
// Shifts a new column into the window, registers the horizontal and vertical
// sums, then clamps each to 0..255 and adds them with saturation.
// ----------------------------------------------------------------------------
module sef_grad (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [sef_pkg::PIX_W-1:0]    i_top,
    input  logic [sef_pkg::PIX_W-1:0]    i_mid,
    input  logic [sef_pkg::PIX_W-1:0]    i_bot,
    input  sef_pkg::t_ctl                i_ctl,
    output sef_pkg::t_pipe_status        o_status,
    output logic                         o_push,
    output logic [sef_pkg::PIX_W-1:0]    o_edge,
    output logic                         o_last
);

    typedef logic signed [10:0] t_grad;

    logic [sef_pkg::PIX_W-1:0] r_win [3][3];
    logic                      r_win_valid;
    sef_pkg::t_ctl             r_win_ctl;
    t_grad                     r_gx;
    t_grad                     r_gy;
    logic                      r_grad_valid;
    sef_pkg::t_ctl             r_grad_ctl;

    logic [9:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic [7:0] cx, cy;
    logic [8:0] sum;

    // clamp a gradient to 0..255, negative goes to 0
    function automatic logic [7:0] clamp_grad(input t_grad g);
        logic [7:0] res;
        if (g < 0) begin
            res = 8'd0;
        end else if (g > 11'sd255) begin
            res = 8'd255;
        end else begin
            res = g[7:0];
        end
        return res;
    endfunction

    // window shift, row 0 is the oldest row
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= i_top;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_bot;
            r_win_ctl   <= i_ctl;
        end
    end

    // gradient sums over the window
    always_comb begin
        gx_pos = 10'(r_win[0][2]) + {1'b0, r_win[1][2], 1'b0} + 10'(r_win[2][2]);
        gx_neg = 10'(r_win[0][0]) + {1'b0, r_win[1][0], 1'b0} + 10'(r_win[2][0]);
        gy_pos = 10'(r_win[2][0]) + {1'b0, r_win[2][1], 1'b0} + 10'(r_win[2][2]);
        gy_neg = 10'(r_win[0][0]) + {1'b0, r_win[0][1], 1'b0} + 10'(r_win[0][2]);
    end

    always_ff @(posedge i_clk) begin
        if (r_win_valid) begin
            r_gx       <= t_grad'({1'b0, gx_pos}) - t_grad'({1'b0, gx_neg});
            r_gy       <= t_grad'({1'b0, gy_pos}) - t_grad'({1'b0, gy_neg});
            r_grad_ctl <= r_win_ctl;
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid  <= 1'b0;
            r_grad_valid <= 1'b0;
        end else begin
            r_win_valid  <= i_valid;
            r_grad_valid <= r_win_valid;
        end
    end

    // clamp and saturating add
    always_comb begin
        cx  = clamp_grad(r_gx);
        cy  = clamp_grad(r_gy);
        sum = 9'(cx) + 9'(cy);
    end

    assign o_edge              = sum[8] ? 8'd255 : sum[7:0];
    assign o_last              = r_grad_ctl.last;
    assign o_push              = r_grad_valid && r_grad_ctl.produce;
    assign o_status.win_valid  = r_win_valid;
    assign o_status.grad_valid = r_grad_valid;

endmodule

[src/sef_out_fifo.sv]
// ----------------------------------------------------------------------------
// sef_out_fifo - output word queue
// Small register queue between the gradient pipeline and the output channel;
// its fill count sets the input credit.
// ----------------------------------------------------------------------------
module sef_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [sef_pkg::PIX_W-1:0]         i_edge,
    input  logic                              i_last,
    output logic [sef_pkg::FIFO_CNT_W-1:0]    o_count,
    sef_out_if.source                         o_out
);

    logic [sef_pkg::PIX_W:0]            r_q [sef_pkg::FIFO_DEPTH];
    logic [sef_pkg::FIFO_PTR_W-1:0]     r_wr_ptr;
    logic [sef_pkg::FIFO_PTR_W-1:0]     r_rd_ptr;
    logic [sef_pkg::FIFO_CNT_W-1:0]     r_count;
    logic                               pop;

    assign pop = o_out.valid && o_out.ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= {i_last, i_edge};
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + sef_pkg::FIFO_CNT_W'(i_push)
                               - sef_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign o_out.valid      = (r_count != '0);
    assign o_out.edge_pixel = r_q[r_rd_ptr][sef_pkg::PIX_W-1:0];
    assign o_out.frame_last = r_q[r_rd_ptr][sef_pkg::PIX_W];
    assign o_count          = r_count;

endmodule

[src/sobel_edge_filter_3x3.sv]
// ----------------------------------------------------------------------------
// sobel_edge_filter_3x3 - 3x3 Sobel edge filter over a pixel raster
// Usage:
//   i_pix  : 8-bit grey pixels in row order, one word per accepted handshake.
//   o_edge : one edge word per interior pixel (row and column at least 2);
//            frame_last marks the final word of the frame. Border pixels
//            give no word.
//   i_cfg  : index 0 frame_rows, index 1 frame_cols (capped at
//            MAX_LINE_WIDTH). Any write to either restarts the frame; other
//            indexes are ignored. Write only while the filter is idle.
// Throughput is one pixel per clock while input credit remains, set by the
// single read and single write per cycle on the line buffer memory. The line
// buffer read is issued at the pixel handshake; the edge word is valid after
// the read stage, window shift, gradient register and output queue write.
// A stalled receiver fills the 8-word output queue; input ready drops once
// queued plus in-flight words reach that depth, and rises as words drain.
// Reset restores frame_rows 720 and frame_cols 1280 and starts a new frame;
// line buffer contents are not cleared; stale entries are read only for
// border pixels of the first two rows, which give no word.
// ----------------------------------------------------------------------------
module sobel_edge_filter_3x3 #(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sef_pix_if.sink    i_pix,
    sef_out_if.source  o_edge,
    sef_cfg_if.sink    i_cfg
);

    localparam int AW = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int CW = $clog2(MAX_LINE_WIDTH + 1);

    logic [sef_pkg::CFG_DATA_W-1:0] r_frame_rows;
    logic [sef_pkg::CFG_DATA_W-1:0] r_frame_cols;
    logic [sef_pkg::ROW_W-1:0]      r_row;
    logic [AW-1:0]                  r_col;

    logic                           r_s1_valid;
    logic [sef_pkg::PIX_W-1:0]      r_s1_px;
    logic [AW-1:0]                  r_s1_col;
    sef_pkg::t_ctl                  r_s1_ctl;

    logic [CW-1:0]                  col_last;
    logic [sef_pkg::ROW_W-1:0]      row_last;
    logic                           at_col_last;
    logic                           at_row_last;
    logic                           pix_acc;
    logic                           cfg_hit;
    sef_pkg::t_ctl                  acc_ctl;
    logic [2*sef_pkg::PIX_W-1:0]    rd_data;
    logic [2*sef_pkg::PIX_W-1:0]    wr_data;
    sef_pkg::t_pipe_status          pipe_st;
    logic                           grad_push;
    logic [sef_pkg::PIX_W-1:0]      grad_edge;
    logic                           grad_last;
    logic [sef_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [sef_pkg::FIFO_CNT_W:0]   credit_used;

    // effective frame size
    always_comb begin
        if (r_frame_cols == '0) begin
            col_last = '0;
        end else if (32'(r_frame_cols) > 32'(MAX_LINE_WIDTH)) begin
            col_last = CW'(MAX_LINE_WIDTH - 1);
        end else begin
            col_last = CW'(r_frame_cols - 1'b1);
        end
        row_last = (r_frame_rows == '0) ? '0 : (r_frame_rows - 1'b1);
    end

    assign at_col_last = (CW'(r_col) == col_last);
    assign at_row_last = (r_row == row_last);

    // handshakes and input credit
    assign cfg_hit     = i_cfg.valid && ((i_cfg.index == sef_pkg::REG_FRAME_ROWS) ||
                                         (i_cfg.index == sef_pkg::REG_FRAME_COLS));
    assign credit_used = (sef_pkg::FIFO_CNT_W + 1)'(fifo_count)
                       + (sef_pkg::FIFO_CNT_W + 1)'(r_s1_valid)
                       + (sef_pkg::FIFO_CNT_W + 1)'(pipe_st.win_valid)
                       + (sef_pkg::FIFO_CNT_W + 1)'(pipe_st.grad_valid);
    assign i_pix.ready = (credit_used < (sef_pkg::FIFO_CNT_W + 1)'(sef_pkg::FIFO_DEPTH));
    assign i_cfg.ready = 1'b1;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    assign acc_ctl.produce = (r_row >= sef_pkg::ROW_W'(2)) && (r_col >= AW'(2));
    assign acc_ctl.last    = at_row_last && at_col_last;

    // configuration registers and raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= sef_pkg::FRAME_ROWS_RST;
            r_frame_cols <= sef_pkg::FRAME_COLS_RST;
            r_row        <= '0;
            r_col        <= '0;
        end else if (cfg_hit) begin
            if (i_cfg.index == sef_pkg::REG_FRAME_ROWS) begin
                r_frame_rows <= i_cfg.data;
            end else begin
                r_frame_cols <= i_cfg.data;
            end
            r_row <= '0;
            r_col <= '0;
        end else if (pix_acc) begin
            if (at_col_last) begin
                r_col <= '0;
                r_row <= at_row_last ? '0 : (r_row + 1'b1);
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // read stage: pixel waits here for the line buffer word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_px  <= i_pix.pixel_in;
            r_s1_col <= r_col;
            r_s1_ctl <= acc_ctl;
        end
    end

    // write back: newer row moves to the older slot, pixel becomes newer row
    assign wr_data = {rd_data[sef_pkg::PIX_W-1:0], r_s1_px};

    sef_line_mem #(
        .DEPTH (MAX_LINE_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (pix_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_valid),
        .i_wr_addr (r_s1_col),
        .i_wr_data (wr_data)
    );

    sef_grad u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_valid),
        .i_top    (rd_data[2*sef_pkg::PIX_W-1:sef_pkg::PIX_W]),
        .i_mid    (rd_data[sef_pkg::PIX_W-1:0]),
        .i_bot    (r_s1_px),
        .i_ctl    (r_s1_ctl),
        .o_status (pipe_st),
        .o_push   (grad_push),
        .o_edge   (grad_edge),
        .o_last   (grad_last)
    );

    sef_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (grad_push),
        .i_edge  (grad_edge),
        .i_last  (grad_last),
        .o_count (fifo_count),
        .o_out   (o_edge)
    );

endmodule

[dv/sef_edge_checker.sv]
// ----------------------------------------------------------------------------
// sef_edge_checker - scoreboard for the 3x3 Sobel edge filter
// Tracks register writes and accepted pixels to keep a copy of the line
// buffers, the 3x3 window and the raster counters. Each interior pixel
// queues the edge word it should produce. Each word that leaves the filter
// is checked field by field against the oldest queued word.
// ----------------------------------------------------------------------------
module sef_edge_checker #(
    parameter int MAX_LINE_WIDTH = 2048
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sef_pix_if   i_pix,
    sef_out_if   i_edge,
    sef_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W   = $clog2(MAX_LINE_WIDTH);
    localparam int PIX_MAX = (1 << sef_pkg::PIX_W) - 1;

    typedef struct packed {
        logic [sef_pkg::PIX_W-1:0] edge_px;
        logic                      last;
    } t_edge_word;

    logic [sef_pkg::CFG_DATA_W-1:0] rows_reg;
    logic [sef_pkg::CFG_DATA_W-1:0] cols_reg;
    logic [sef_pkg::PIX_W-1:0]      line_mem [2][MAX_LINE_WIDTH];
    logic [sef_pkg::PIX_W-1:0]      win [3][3];
    logic [sef_pkg::ROW_W-1:0]      row_cnt;
    logic [COL_W-1:0]               col_cnt;
    t_edge_word                     edge_queue [$];

    // negative gradients go to zero, not to their magnitude
    function automatic int clamp_to_pixel(input int v);
        if (v < 0) return 0;
        if (v > PIX_MAX) return PIX_MAX;
        return v;
    endfunction

    function automatic logic [sef_pkg::PIX_W-1:0] edge_strength();
        int gx;
        int gy;
        int sum;
        gx = int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2])
           - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
        gy = int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2])
           - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
        sum = clamp_to_pixel(gx) + clamp_to_pixel(gy);
        if (sum > PIX_MAX) sum = PIX_MAX;
        return sum[sef_pkg::PIX_W-1:0];
    endfunction

    // shift one pixel into the window and line buffers, queue its edge word if interior
    task automatic shift_in_pixel(input logic [sef_pkg::PIX_W-1:0] px);
        int unsigned rows_eff;
        int unsigned cols_eff;
        t_edge_word  w;
        rows_eff = (rows_reg == 0) ? 1 : rows_reg;
        cols_eff = (cols_reg == 0) ? 1 : cols_reg;
        if (cols_eff > MAX_LINE_WIDTH) cols_eff = MAX_LINE_WIDTH;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2]         = line_mem[0][col_cnt];
        win[1][2]         = line_mem[1][col_cnt];
        line_mem[0][col_cnt] = line_mem[1][col_cnt];
        win[2][2]         = px;
        line_mem[1][col_cnt] = px;

        // interior pixels only
        if (row_cnt >= 2 && col_cnt >= 2) begin
            w.edge_px = edge_strength();
            w.last    = (int'(row_cnt) == rows_eff - 1) && (int'(col_cnt) == cols_eff - 1);
            edge_queue.push_back(w);
        end

        // raster counters wrap at the end of the row and of the frame
        if (int'(col_cnt) + 1 >= cols_eff) begin
            col_cnt = '0;
            if (int'(row_cnt) + 1 >= rows_eff) row_cnt = '0;
            else row_cnt = row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_edge_word got;
        t_edge_word want;
        if (!i_rst_n) begin
            rows_reg = sef_pkg::FRAME_ROWS_RST;
            cols_reg = sef_pkg::FRAME_COLS_RST;
            row_cnt  = '0;
            col_cnt  = '0;
            edge_queue.delete();
            for (int k = 0; k < 3; k++) begin
                for (int m = 0; m < 3; m++) win[k][m] = '0;
            end
            for (int m = 0; m < MAX_LINE_WIDTH; m++) begin
                line_mem[0][m] = '0;
                line_mem[1][m] = '0;
            end
            o_fail_count = 0;
        end else begin
            // outgoing edge word against the oldest expectation
            if (i_edge.valid && i_edge.ready) begin
                got.edge_px = i_edge.edge_pixel;
                got.last    = i_edge.frame_last;
                if (edge_queue.size() == 0) begin
                    $display("%0t: unexpected edge word: edge_pixel %0d frame_last %0b",
                             $time, got.edge_px, got.last);
                    o_fail_count++;
                end else begin
                    want = edge_queue.pop_front();
                    if (got.edge_px !== want.edge_px) begin
                        $display("%0t: edge_pixel mismatch: expected %0d, actual %0d",
                                 $time, want.edge_px, got.edge_px);
                        o_fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                                 $time, want.last, got.last);
                        o_fail_count++;
                    end
                end
            end

            // any write to a mapped register restarts the frame
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    sef_pkg::REG_FRAME_ROWS: begin
                        rows_reg = i_cfg.data;
                        row_cnt  = '0;
                        col_cnt  = '0;
                    end
                    sef_pkg::REG_FRAME_COLS: begin
                        cols_reg = i_cfg.data;
                        row_cnt  = '0;
                        col_cnt  = '0;
                    end
                    default: ;
                endcase
            end

            if (i_pix.valid && i_pix.ready) shift_in_pixel(i_pix.pixel_in);
        end
        o_words_due = edge_queue.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for the 3x3 Sobel edge filter
// Drives pixel frames and register writes: a directed part for gradient
// clamping, unmapped and restarting writes and degenerate frame sizes, then
// random frames of several sizes and pixel patterns, a receiver hold-off
// that backs up the filter, and the largest row and column settings.
// Random idling on both channels; the checker scores every edge word.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE      = 2048;
    localparam int IDLE_PCT      = 36;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_PIXELS = 650;
    localparam int WIDE_PIXELS   = 200;
    localparam logic [sef_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = '1;
    localparam logic [sef_pkg::PIX_W-1:0]     PIX_WHITE    = '1;
    localparam logic [sef_pkg::PIX_W-1:0]     PIX_BLACK    = '0;

    typedef enum logic [1:0] {
        PAT_NOISE,
        PAT_BINARY,
        PAT_RAMP
    } t_pattern;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic no_idle = 1'b0;
    int   hold_requests = 0;
    int   fail_count;
    int   words_due;
    int   rows_cur;
    int   cols_cur;

    sef_pix_if pix ();
    sef_out_if edges ();
    sef_cfg_if cfg ();

    sobel_edge_filter_3x3 #(
        .MAX_LINE_WIDTH(MAX_LINE)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .o_edge (edges),
        .i_cfg  (cfg)
    );

    sef_edge_checker #(
        .MAX_LINE_WIDTH(MAX_LINE)
    ) u_scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix),
        .i_edge      (edges),
        .i_cfg       (cfg),
        .o_fail_count(fail_count),
        .o_words_due (words_due)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #500_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random ready, or a long hold-off on request
    initial begin
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        edges.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                edges.ready <= 1'b0;
            end else if (no_idle) begin
                edges.ready <= 1'b1;
            end else begin
                edges.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // one pixel word; valid stays high after acceptance until the next call
    task automatic send_pixel(input logic [sef_pkg::PIX_W-1:0] px);
        @(negedge i_clk);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                pix.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        pix.valid    <= 1'b1;
        pix.pixel_in <= px;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    task automatic send_pattern(input int count, input t_pattern pat, input int base);
        logic [sef_pkg::PIX_W-1:0] px;
        for (int i = 0; i < count; i++) begin
            case (pat)
                PAT_BINARY: px = $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
                PAT_RAMP:   px = sef_pkg::PIX_W'(base + $urandom_range(6));
                default:    px = sef_pkg::PIX_W'($urandom_range(255));
            endcase
            send_pixel(px);
        end
    endtask

    // stop offering pixels and let every word and in-flight border pixel drain
    task automatic settle();
        @(negedge i_clk);
        pix.valid <= 1'b0;
        wait (words_due == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sef_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sef_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == sef_pkg::REG_FRAME_ROWS) rows_cur = val;
        if (idx == sef_pkg::REG_FRAME_COLS) cols_cur = val;
    endtask

    initial begin
        int       rows_eff;
        int       cols_eff;
        int       frame_pixels;
        int       random_sent;
        t_pattern pat;

        pix.valid    = 1'b0;
        pix.pixel_in = '0;
        cfg.valid    = 1'b0;
        cfg.index    = '0;
        cfg.data     = '0;
        rows_cur     = sef_pkg::FRAME_ROWS_RST;
        cols_cur     = sef_pkg::FRAME_COLS_RST;
        random_sent  = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // strong positive horizontal gradient saturates; an unmapped write
        // in mid-frame must not restart the frame
        write_reg(sef_pkg::REG_FRAME_ROWS, 12'd3);
        write_reg(sef_pkg::REG_FRAME_COLS, 12'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) begin
                settle();
                write_reg(REG_UNMAPPED, sef_pkg::CFG_DATA_W'($urandom_range(4095)));
            end
            send_pixel((i % 3 == 2) ? PIX_WHITE : PIX_BLACK);
        end

        // a mapped write mid-frame restarts it; negative vertical gradient
        // clamps to zero
        send_pattern(5, PAT_NOISE, 0);
        settle();
        write_reg(sef_pkg::REG_FRAME_ROWS, 12'd3);
        for (int i = 0; i < 9; i++) send_pixel((i < 3) ? PIX_WHITE : PIX_BLACK);

        // zero rows and columns behave as one: pixels consumed, no words
        settle();
        write_reg(sef_pkg::REG_FRAME_ROWS, '0);
        write_reg(sef_pkg::REG_FRAME_COLS, '0);
        send_pattern(3, PAT_BINARY, 0);

        // receiver holds off while the sender keeps pushing a full frame
        settle();
        write_reg(sef_pkg::REG_FRAME_ROWS, 12'd6);
        write_reg(sef_pkg::REG_FRAME_COLS, 12'd10);
        no_idle = 1'b1;
        hold_requests++;
        send_pattern(60, PAT_NOISE, 0);
        settle();
        no_idle = 1'b0;

        // random frames, partial frames and occasional reconfiguration
        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(3) != 0) begin
                settle();
                if ($urandom_range(1)) begin
                    write_reg(sef_pkg::REG_FRAME_ROWS, ($urandom_range(99) < 8) ?
                              sef_pkg::CFG_DATA_W'($urandom_range(2)) :
                              sef_pkg::CFG_DATA_W'($urandom_range(3, 8)));
                    write_reg(sef_pkg::REG_FRAME_COLS, ($urandom_range(99) < 8) ?
                              sef_pkg::CFG_DATA_W'($urandom_range(2)) :
                              sef_pkg::CFG_DATA_W'($urandom_range(3, 12)));
                end else begin
                    write_reg(sef_pkg::REG_FRAME_COLS, ($urandom_range(99) < 8) ?
                              sef_pkg::CFG_DATA_W'($urandom_range(2)) :
                              sef_pkg::CFG_DATA_W'($urandom_range(3, 12)));
                    write_reg(sef_pkg::REG_FRAME_ROWS, ($urandom_range(99) < 8) ?
                              sef_pkg::CFG_DATA_W'($urandom_range(2)) :
                              sef_pkg::CFG_DATA_W'($urandom_range(3, 8)));
                end
            end
            rows_eff = (rows_cur == 0) ? 1 : rows_cur;
            cols_eff = (cols_cur == 0) ? 1 : ((cols_cur > MAX_LINE) ? MAX_LINE : cols_cur);
            frame_pixels = rows_eff * cols_eff * $urandom_range(1, 2);
            if ($urandom_range(99) < 15) frame_pixels = $urandom_range(1, frame_pixels);
            no_idle = ($urandom_range(7) == 0);
            if ($urandom_range(9) == 0) hold_requests++;
            pat = t_pattern'($urandom_range(2));
            send_pattern(frame_pixels, pat, $urandom_range(249));
            if (rows_eff >= 3 && cols_eff >= 3) random_sent += frame_pixels;
        end
        no_idle = 1'b0;

        // column count beyond the line buffer acts as its depth; a long
        // unbroken stretch of the first row with no idling
        settle();
        write_reg(sef_pkg::REG_FRAME_ROWS, 12'd3);
        write_reg(sef_pkg::REG_FRAME_COLS, '1);
        no_idle = 1'b1;
        send_pattern(WIDE_PIXELS, PAT_NOISE, 0);

        // largest row count, narrow frame, cut short
        settle();
        write_reg(sef_pkg::REG_FRAME_COLS, 12'd3);
        write_reg(sef_pkg::REG_FRAME_ROWS, '1);
        no_idle = 1'b0;
        send_pattern(30, PAT_NOISE, 0);

        settle();
        if (fail_count == 0 && words_due == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
